// ----- rtl/cwq_pkg.sv -----
// ----------------------------------------------------------------------------
// cwq_pkg: shared types and constants of the condition wait queue
// Opcodes, result status codes, control state encodings, cell operations
// and the fixed port widths.
// ----------------------------------------------------------------------------
package cwq_pkg;

    // Default sizes of the queue.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // Fixed widths of the port fields.
    localparam int OPCODE_W = 2;
    localparam int EXT_ID_W = 8;
    localparam int STATUS_W = 2;
    localparam int LEFT_W   = 5;

    // Request opcodes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_WAIT   = 2'd0,
        OP_SIGNAL = 2'd1,
        OP_BCAST  = 2'd2,
        OP_CANCEL = 2'd3
    } opcode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_TIMEOUT = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    // Control states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BCAST,
        ST_CANCEL
    } state_t;

    // Operation applied to every cell of the chain together.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

endpackage

// ----- rtl/condition_wait_queue.sv -----
// ----------------------------------------------------------------------------
// condition_wait_queue: FIFO waiter queue of a condition variable
// Wait, signal, broadcast and timeout cancel on a row of waiter cells.
// ----------------------------------------------------------------------------
// A wait, a signal, and any operation on an empty queue give one result word
// in the cycle after the request word is taken. A broadcast of n queued
// waiters gives n result words, one per cycle unless the result channel
// stalls, as the chain shifts its oldest waiter out at the head. A cancel on
// a queue of n waiters rotates the chain once through all n occupied cells,
// one cell per cycle, dropping the oldest matching id as it passes the head;
// its result word follows once the rotation is done. One request word is
// worked on at a time: a new request word is taken only when the previous
// result word has been taken or is taken in the same cycle, and every stall
// on the result channel holds back the results.
module condition_wait_queue #(
    parameter int QUEUE_DEPTH = cwq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = cwq_pkg::ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel.
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [cwq_pkg::OPCODE_W-1:0]  opcode,
    input  logic [cwq_pkg::EXT_ID_W-1:0]  waiter_id,
    // Result channel.
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          grant_valid,
    output logic [cwq_pkg::EXT_ID_W-1:0]  granted_id,
    output logic [cwq_pkg::STATUS_W-1:0]  status,
    output logic                          last,
    output logic [cwq_pkg::LEFT_W-1:0]    waiters_left
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int EW = cwq_pkg::EXT_ID_W;
    localparam int LW = cwq_pkg::LEFT_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    // Control state.
    cwq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic               found_reg, found_next;
    logic [ID_BITS-1:0] id_reg, id_next;

    // Output register.
    logic                        out_valid_reg;
    logic                        gv_reg;
    logic [EW-1:0]               gid_reg;
    cwq_pkg::status_t            st_reg;
    logic                        last_reg;
    logic [LW-1:0]               left_reg;

    // Values loaded into the output register.
    logic                        ld;
    logic                        ld_gv;
    logic [EW-1:0]               ld_gid;
    cwq_pkg::status_t            ld_st;
    logic                        ld_last;
    logic [CW-1:0]               ld_left;

    // Chain control.
    cwq_pkg::cell_op_t  cell_op;
    logic [IW-1:0]      cell_sel;
    logic [ID_BITS-1:0] req_id;
    logic [ID_BITS-1:0] head_id;
    logic [ID_BITS-1:0] slot_q [QUEUE_DEPTH];

    logic out_free;
    logic req_take;
    logic drop;

    assign req_id   = ID_BITS'(waiter_id);
    assign head_id  = slot_q[0];
    assign out_free = !out_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == cwq_pkg::ST_IDLE) && out_free);
    assign req_take = req_valid && !req_stall;
    assign drop     = !found_reg && (head_id == id_reg);

    // Row of waiter cells; cell 0 holds the oldest waiter.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [ID_BITS-1:0] right_id;

        if (i == QUEUE_DEPTH - 1)
        begin : g_end
            assign right_id = '0;
        end
        else
        begin : g_mid
            assign right_id = slot_q[i+1];
        end

        cwq_cell #(
            .IDX     (i),
            .SEL_W   (IW),
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk      (clk),
            .op       (cell_op),
            .sel      (cell_sel),
            .new_id   (req_id),
            .head_id  (head_id),
            .right_id (right_id),
            .slot_id  (slot_q[i])
        );
    end

    // Sequencer: next state, chain operation and result word.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        found_next = found_reg;
        id_next    = id_reg;
        cell_op    = cwq_pkg::CELL_HOLD;
        cell_sel   = '0;
        ld         = 1'b0;
        ld_gv      = 1'b0;
        ld_gid     = '0;
        ld_st      = cwq_pkg::STAT_OK;
        ld_last    = 1'b1;
        ld_left    = count_reg;

        case (state_reg)
            cwq_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    case (cwq_pkg::opcode_t'(opcode))
                        cwq_pkg::OP_WAIT:
                        begin
                            ld = 1'b1;
                            if (count_reg == FULL_COUNT)
                            begin
                                ld_st = cwq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cell_op    = cwq_pkg::CELL_APPEND;
                                cell_sel   = IW'(count_reg);
                                count_next = count_reg + ONE;
                                ld_left    = count_reg + ONE;
                            end
                        end
                        cwq_pkg::OP_SIGNAL:
                        begin
                            ld = 1'b1;
                            if (count_reg != '0)
                            begin
                                ld_gv      = 1'b1;
                                ld_gid     = EW'(head_id);
                                cell_op    = cwq_pkg::CELL_SHIFT;
                                count_next = count_reg - ONE;
                                ld_left    = count_reg - ONE;
                            end
                        end
                        cwq_pkg::OP_BCAST:
                        begin
                            if (count_reg == '0)
                            begin
                                ld = 1'b1;
                            end
                            else
                            begin
                                count_next = '0;
                                rem_next   = count_reg;
                                state_next = cwq_pkg::ST_BCAST;
                            end
                        end
                        cwq_pkg::OP_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                ld = 1'b1;
                            end
                            else
                            begin
                                id_next    = req_id;
                                rem_next   = count_reg;
                                found_next = 1'b0;
                                state_next = cwq_pkg::ST_CANCEL;
                            end
                        end
                        default:
                        begin
                            ld = 1'b0;
                        end
                    endcase
                end
            end
            cwq_pkg::ST_BCAST:
            begin
                // Shift one waiter out of the head per result word.
                if (out_free)
                begin
                    ld       = 1'b1;
                    ld_gv    = 1'b1;
                    ld_gid   = EW'(head_id);
                    ld_last  = (rem_reg == ONE);
                    ld_left  = '0;
                    cell_op  = cwq_pkg::CELL_SHIFT;
                    rem_next = rem_reg - ONE;
                    if (rem_reg == ONE)
                    begin
                        state_next = cwq_pkg::ST_IDLE;
                    end
                end
            end
            cwq_pkg::ST_CANCEL:
            begin
                if (rem_reg != '0)
                begin
                    // Move the head to the tail, or drop it on the first match.
                    rem_next = rem_reg - ONE;
                    if (drop)
                    begin
                        cell_op    = cwq_pkg::CELL_SHIFT;
                        count_next = count_reg - ONE;
                        found_next = 1'b1;
                    end
                    else
                    begin
                        cell_op  = cwq_pkg::CELL_ROTATE;
                        cell_sel = IW'(count_reg - ONE);
                    end
                end
                else if (out_free)
                begin
                    ld         = 1'b1;
                    ld_st      = found_reg ? cwq_pkg::STAT_TIMEOUT : cwq_pkg::STAT_OK;
                    state_next = cwq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cwq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cwq_pkg::ST_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            found_reg <= found_next;
        end
    end

    // Cancel id register; payload only.
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            gv_reg   <= ld_gv;
            gid_reg  <= ld_gid;
            st_reg   <= ld_st;
            last_reg <= ld_last;
            left_reg <= LW'(ld_left);
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign grant_valid  = gv_reg;
    assign granted_id   = gid_reg;
    assign status       = st_reg;
    assign last         = last_reg;
    assign waiters_left = left_reg;

`ifndef SYNTHESIS
    // The waiter count never passes the number of cells.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("waiter count exceeds queue depth");

    // During a broadcast the queue is already recorded as empty.
    a_bcast_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cwq_pkg::ST_BCAST) |-> (count_reg == '0))
        else $error("queue not empty during broadcast");

    // The rotations left in a cancel never exceed the queued waiters.
    a_cancel_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cwq_pkg::ST_CANCEL) |-> (rem_reg <= count_reg))
        else $error("cancel rotation count out of step with queue");

    // A grant always carries the ok status.
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && grant_valid) |-> (status == cwq_pkg::STAT_OK))
        else $error("grant with non-ok status");
`endif

endmodule

// ----- rtl/cwq_cell.sv -----
// ----------------------------------------------------------------------------
// cwq_cell: one slot of the waiter chain
// Holds one waiter id. Takes a new id when it is the selected slot of an
// append, the id of its right neighbor on a shift, and on a rotation the
// head id when it is the selected tail slot, else its right neighbor's id.
// ----------------------------------------------------------------------------
module cwq_cell #(
    parameter int IDX     = 0,
    parameter int SEL_W   = 4,
    parameter int ID_BITS = cwq_pkg::ID_BITS_DEF
) (
    input  logic                 clk,
    input  cwq_pkg::cell_op_t    op,
    input  logic [SEL_W-1:0]     sel,
    input  logic [ID_BITS-1:0]   new_id,
    input  logic [ID_BITS-1:0]   head_id,
    input  logic [ID_BITS-1:0]   right_id,
    output logic [ID_BITS-1:0]   slot_id
);

    localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(IDX);

    logic [ID_BITS-1:0] slot_reg;
    logic [ID_BITS-1:0] slot_next;
    logic               hit;

    assign hit = (sel == MY_IDX);

    // Next slot value for the operation of this cycle.
    always_comb
    begin
        slot_next = slot_reg;
        case (op)
            cwq_pkg::CELL_APPEND:
            begin
                if (hit)
                begin
                    slot_next = new_id;
                end
            end
            cwq_pkg::CELL_SHIFT:
            begin
                slot_next = right_id;
            end
            cwq_pkg::CELL_ROTATE:
            begin
                slot_next = hit ? head_id : right_id;
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    // Slot storage; payload only, no reset.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_id = slot_reg;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the condition wait queue
// Sends wait, signal, broadcast and cancel request words with random gaps,
// stalls the result channel at random, and compares every result word with
// a queue model that the testbench keeps of its own.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned RANDOM_WORDS = 280;
    localparam int unsigned QUIET_TAIL   = 40;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    typedef struct {
        cwq_pkg::opcode_t                op;
        logic [cwq_pkg::EXT_ID_W-1:0]    id;
    } request_word_t;

    typedef struct {
        logic                            grant_valid;
        logic [cwq_pkg::EXT_ID_W-1:0]    granted_id;
        cwq_pkg::status_t                status;
        logic                            last;
        logic [cwq_pkg::LEFT_W-1:0]      waiters_left;
    } result_word_t;

    // Clock, reset and the ports of the block.
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    logic [cwq_pkg::OPCODE_W-1:0]    opcode = '0;
    logic [cwq_pkg::EXT_ID_W-1:0]    waiter_id = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    logic                            grant_valid;
    logic [cwq_pkg::EXT_ID_W-1:0]    granted_id;
    logic [cwq_pkg::STATUS_W-1:0]    status;
    logic                            last;
    logic [cwq_pkg::LEFT_W-1:0]      waiters_left;

    // Stimulus, queue model and expected result words.
    request_word_t                       pending_requests[$];
    logic [cwq_pkg::ID_BITS_DEF-1:0]     waiting_ids[$];
    result_word_t                        expected_results[$];

    int unsigned send_gap;
    int unsigned stall_gap;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned grants_predicted;
    int unsigned timeouts_predicted;
    int unsigned full_predicted;
    int unsigned deepest_queue;

    condition_wait_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .waiter_id    (waiter_id),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .grant_valid  (grant_valid),
        .granted_id   (granted_id),
        .status       (status),
        .last         (last),
        .waiters_left (waiters_left)
    );

    always #2 clk = ~clk;

    // Print one error line and count it.
    task automatic note_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic push_request(input cwq_pkg::opcode_t op,
                                input logic [cwq_pkg::EXT_ID_W-1:0] id);
        request_word_t word;
        word.op = op;
        word.id = id;
        pending_requests.push_back(word);
    endtask

    function automatic result_word_t make_result(input logic gv,
                                                 input logic [cwq_pkg::EXT_ID_W-1:0] gid,
                                                 input cwq_pkg::status_t st,
                                                 input logic lst,
                                                 input int unsigned left);
        result_word_t r;
        r.grant_valid  = gv;
        r.granted_id   = gid;
        r.status       = st;
        r.last         = lst;
        r.waiters_left = cwq_pkg::LEFT_W'(left);
        return r;
    endfunction

    // Apply one accepted request word to the queue model and queue up the
    // result words that it must produce.
    task automatic predict_request(input cwq_pkg::opcode_t op,
                                   input logic [cwq_pkg::EXT_ID_W-1:0] raw_id);
        logic [cwq_pkg::ID_BITS_DEF-1:0] id;
        int                              hit;
        int unsigned                     n;
        id = raw_id[cwq_pkg::ID_BITS_DEF-1:0];
        words_sent++;
        case (op)
            cwq_pkg::OP_WAIT:
            begin
                if (waiting_ids.size() >= cwq_pkg::QUEUE_DEPTH_DEF)
                begin
                    full_predicted++;
                    expected_results.push_back(make_result(1'b0, '0, cwq_pkg::STAT_FULL,
                                                           1'b1, waiting_ids.size()));
                end
                else
                begin
                    waiting_ids.push_back(id);
                    expected_results.push_back(make_result(1'b0, '0, cwq_pkg::STAT_OK,
                                                           1'b1, waiting_ids.size()));
                end
                if (waiting_ids.size() > deepest_queue)
                    deepest_queue = waiting_ids.size();
            end
            cwq_pkg::OP_SIGNAL:
            begin
                if (waiting_ids.size() == 0)
                begin
                    expected_results.push_back(make_result(1'b0, '0, cwq_pkg::STAT_OK,
                                                           1'b1, 0));
                end
                else
                begin
                    grants_predicted++;
                    id = waiting_ids.pop_front();
                    expected_results.push_back(make_result(1'b1,
                                                           cwq_pkg::EXT_ID_W'(id),
                                                           cwq_pkg::STAT_OK, 1'b1,
                                                           waiting_ids.size()));
                end
            end
            cwq_pkg::OP_BCAST:
            begin
                n = waiting_ids.size();
                if (n == 0)
                    expected_results.push_back(make_result(1'b0, '0, cwq_pkg::STAT_OK,
                                                           1'b1, 0));
                for (int unsigned i = 0; i < n; i++)
                begin
                    grants_predicted++;
                    expected_results.push_back(make_result(1'b1,
                                                           cwq_pkg::EXT_ID_W'(waiting_ids[i]),
                                                           cwq_pkg::STAT_OK, i + 1 == n, 0));
                end
                waiting_ids.delete();
            end
            default:
            begin
                // A timed-out waiter leaves from wherever it stands; the
                // oldest copy of a repeated id goes first.
                hit = -1;
                for (int i = 0; i < waiting_ids.size(); i++)
                begin
                    if (hit < 0 && waiting_ids[i] == id)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    timeouts_predicted++;
                    waiting_ids.delete(hit);
                    expected_results.push_back(make_result(1'b0, '0, cwq_pkg::STAT_TIMEOUT,
                                                           1'b1, waiting_ids.size()));
                end
                else
                begin
                    expected_results.push_back(make_result(1'b0, '0, cwq_pkg::STAT_OK,
                                                           1'b1, waiting_ids.size()));
                end
            end
        endcase
    endtask

    // Random traffic in episodes: a run of waits from a small pool of ids,
    // then a mix of signals, cancels and further waits, often closed by a
    // broadcast. Stray ids and signals on an empty queue come in as noise.
    task automatic queue_random_traffic(input int unsigned words);
        int unsigned                     count;
        int unsigned                     burst;
        int unsigned                     pick;
        logic [cwq_pkg::EXT_ID_W-1:0]    base;
        count = 0;
        while (count < words)
        begin
            base = cwq_pkg::EXT_ID_W'($urandom_range(0, 255));
            burst = $urandom_range(1, 18);
            for (int unsigned k = 0; k < burst; k++)
            begin
                push_request(cwq_pkg::OP_WAIT,
                             base + cwq_pkg::EXT_ID_W'($urandom_range(0, 7)));
                count++;
            end
            burst = $urandom_range(2, 12);
            for (int unsigned k = 0; k < burst; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    push_request(cwq_pkg::OP_CANCEL,
                                 base + cwq_pkg::EXT_ID_W'($urandom_range(0, 7)));
                else if (pick < 5)
                    push_request(cwq_pkg::OP_SIGNAL, cwq_pkg::EXT_ID_W'($urandom));
                else if (pick < 8)
                    push_request(cwq_pkg::OP_WAIT,
                                 base + cwq_pkg::EXT_ID_W'($urandom_range(0, 7)));
                else if (pick == 8)
                    push_request(cwq_pkg::OP_CANCEL, cwq_pkg::EXT_ID_W'($urandom));
                else
                    push_request(cwq_pkg::OP_WAIT, cwq_pkg::EXT_ID_W'($urandom));
                count++;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                push_request(cwq_pkg::OP_BCAST, cwq_pkg::EXT_ID_W'($urandom));
                count++;
            end
        end
    endtask

    // Request driver: holds a stalled word, otherwise idles in bursts or
    // presents the next pending word.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        request_word_t word;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            opcode    <= '0;
            waiter_id <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predict_request(cwq_pkg::opcode_t'(opcode), waiter_id);
            if (!req_valid || !req_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap  <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_requests.size() == 0)
                begin
                    req_valid <= 1'b0;
                end
                else if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                begin
                    send_gap  <= $urandom_range(0, 18);
                    req_valid <= 1'b0;
                end
                else
                begin
                    word = pending_requests.pop_front();
                    req_valid <= 1'b1;
                    opcode    <= word.op;
                    waiter_id <= word.id;
                end
            end
        end
    end

    // Result monitor: checks every accepted result word against the oldest
    // expectation and stalls the channel in random bursts.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        result_word_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_gap <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    note_error("result word arrived with nothing expected");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (grant_valid !== want.grant_valid)
                        note_error($sformatf("grant_valid expected %0h, got %0h",
                                             want.grant_valid, grant_valid));
                    if (granted_id !== want.granted_id)
                        note_error($sformatf("granted_id expected %0h, got %0h",
                                             want.granted_id, granted_id));
                    if (status !== want.status)
                        note_error($sformatf("status expected %0h, got %0h",
                                             want.status, status));
                    if (last !== want.last)
                        note_error($sformatf("last expected %0h, got %0h", want.last, last));
                    if (waiters_left !== want.waiters_left)
                        note_error($sformatf("waiters_left expected %0d, got %0d",
                                             want.waiters_left, waiters_left));
                end
            end
            if (stall_gap != 0)
            begin
                stall_gap <= stall_gap - 1;
                rsp_stall <= 1'b1;
            end
            else if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
            begin
                stall_gap <= $urandom_range(0, 18);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        error_count = 0;
        words_sent = 0;
        results_checked = 0;
        grants_predicted = 0;
        timeouts_predicted = 0;
        full_predicted = 0;
        deepest_queue = 0;

        // Extreme ids through a wait and a signal, then every operation on
        // an empty queue.
        push_request(cwq_pkg::OP_WAIT, 8'h00);
        push_request(cwq_pkg::OP_WAIT, 8'hFF);
        push_request(cwq_pkg::OP_SIGNAL, 8'h00);
        push_request(cwq_pkg::OP_SIGNAL, 8'hFF);
        push_request(cwq_pkg::OP_SIGNAL, 8'h5A);
        push_request(cwq_pkg::OP_BCAST, 8'hA5);
        push_request(cwq_pkg::OP_CANCEL, 8'hA5);

        // Fill the queue with one repeated id, then wait on a full queue.
        for (int unsigned i = 0; i < cwq_pkg::QUEUE_DEPTH_DEF; i++)
            push_request(cwq_pkg::OP_WAIT,
                         (i == 9) ? 8'h33 : cwq_pkg::EXT_ID_W'(i * 16 + 3));
        push_request(cwq_pkg::OP_WAIT, 8'hC3);

        // Cancel the repeated id (oldest copy goes), a missing id and the
        // head, then a signal and a broadcast of what is left.
        push_request(cwq_pkg::OP_CANCEL, 8'h33);
        push_request(cwq_pkg::OP_CANCEL, 8'h7E);
        push_request(cwq_pkg::OP_CANCEL, 8'h03);
        push_request(cwq_pkg::OP_SIGNAL, 8'h00);
        push_request(cwq_pkg::OP_BCAST, 8'h00);

        queue_random_traffic(RANDOM_WORDS);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d request words and checked %0d result words.",
                 words_sent, results_checked);
        $display("Covered %0d grants, %0d timeout removals, %0d full refusals, depth %0d.",
                 grants_predicted, timeouts_predicted, full_predicted, deepest_queue);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cwq_pkg.sv
rtl/cwq_cell.sv
rtl/condition_wait_queue.sv
verif/tb.sv
